FILE: rtl/core/sbc_pkg.sv
// ----------------------------------------------------------------------------
// sbc_pkg
// Types and constants shared by the sprite box collision block.
// ----------------------------------------------------------------------------
`default_nettype none

package sbc_pkg;

    // Command codes on func
    typedef enum logic [1:0] {
        FUNC_WRITE  = 2'd0,
        FUNC_QUERY  = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    // Box edges need room for a full-range pixel position plus 255
    localparam int COORD_W = 18;

    typedef struct packed {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [7:0]  width;
        logic [7:0]  height;
        logic [6:0]  inset_left;
        logic [6:0]  inset_right;
        logic [6:0]  inset_top;
        logic [6:0]  inset_bottom;
        logic [7:0]  hit_mask;
    } entry_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] l;
        logic signed [COORD_W-1:0] r;
        logic signed [COORD_W-1:0] t;
        logic signed [COORD_W-1:0] b;
    } box_t;

endpackage

`default_nettype wire

FILE: rtl/core/sbc_ram.sv
// ----------------------------------------------------------------------------
// sbc_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/sbc_box.sv
// ----------------------------------------------------------------------------
// sbc_box
// Inset bounding box of one entry, in whole pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_box #(
    parameter int FRAC_BITS = 4
) (
    input  wire sbc_pkg::entry_t entry,
    output sbc_pkg::box_t        box
);

    localparam int CW = sbc_pkg::COORD_W;

    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;

    // floor division by 2^FRAC_BITS
    assign px = CW'($signed(entry.pos_x)) >>> FRAC_BITS;
    assign py = CW'($signed(entry.pos_y)) >>> FRAC_BITS;

    assign box.l = px + signed'(CW'(entry.inset_left));
    assign box.r = px + signed'(CW'(entry.width)) - signed'(CW'(entry.inset_right));
    assign box.t = py + signed'(CW'(entry.inset_top));
    assign box.b = py + signed'(CW'(entry.height)) - signed'(CW'(entry.inset_bottom));

endmodule

`default_nettype wire

FILE: rtl/core/sprite_box_collision.sv
// ----------------------------------------------------------------------------
// sprite_box_collision
// Sprite entry table with inset bounding-box collision queries.
// ----------------------------------------------------------------------------
// Usage:
//   A command transaction is taken when start is high and busy is low.
//   func selects write entry, query collisions or remove entry.
//   Write and remove finish in the accepting cycle and give no result;
//   busy stays low, so commands may follow back to back.
//   A query reads its own entry, then scans the table one slot per cycle
//   from slot 0 up, through the single read port of the entry RAM.
//   Each hit is shown for one cycle with strobe high; last marks the final
//   result. A query with no hit gives one empty result (hit_valid low).
//   A query that cannot hit (bad slot, inactive slot, max_hits 0) answers
//   the cycle after start. Otherwise busy holds through ST_SELF, the scan
//   and ST_FLUSH (the scan ends early when max_hits is reached), and the final
//   result is on the ports in the first cycle with busy low again.
//   No new command is taken until a query is through; its scan sets the rate.
//   The receiver cannot stall results; each is valid for one cycle only.
//   Reset clears every active flag (flip-flops, at once); entry data in
//   the RAM is left as is and is only used for active slots.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_box_collision #(
    parameter int ENTRIES   = 16,
    parameter int FRAC_BITS = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  func,
    input  wire logic [3:0]  slot,
    input  wire logic [15:0] pos_x,
    input  wire logic [15:0] pos_y,
    input  wire logic [7:0]  width,
    input  wire logic [7:0]  height,
    input  wire logic [6:0]  inset_left,
    input  wire logic [6:0]  inset_right,
    input  wire logic [6:0]  inset_top,
    input  wire logic [6:0]  inset_bottom,
    input  wire logic [7:0]  hit_mask,
    input  wire logic [3:0]  max_hits,
    output logic             strobe,
    output logic             hit_valid,
    output logic [3:0]       hit_slot,
    output logic [3:0]       hit_count,
    output logic             last
);

    localparam int AW = $clog2(ENTRIES);
    // slot and index, plus one bit so that ENTRIES itself fits
    localparam int SW = ((AW > 4) ? AW : 4) + 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SELF  = 4'b0010,   // own entry arriving from RAM
        ST_SCAN  = 4'b0100,   // one table entry per cycle
        ST_FLUSH = 4'b1000    // emit held hit as last, or empty result
    } state_t;

    // ---------------- state ----------------
    state_t               state_reg, state_next;
    logic [ENTRIES-1:0]   active_reg, active_next;
    logic [AW-1:0]        self_idx_reg, self_idx_next;
    logic [AW-1:0]        sc_reg, sc_next;          // index of entry on rdata
    logic [3:0]           max_reg, max_next;
    logic [3:0]           count_reg, count_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [3:0]           pend_slot_reg, pend_slot_next;
    logic [3:0]           pend_count_reg, pend_count_next;
    sbc_pkg::box_t        self_box_reg, self_box_next;
    logic [7:0]           self_mask_reg, self_mask_next;

    logic                 strobe_reg, strobe_next;
    logic                 hit_valid_reg, hit_valid_next;
    logic [3:0]           hit_slot_reg, hit_slot_next;
    logic [3:0]           hit_count_reg, hit_count_next;
    logic                 last_reg, last_next;

    // ---------------- command decode ----------------
    logic                 accept;
    logic [SW-1:0]        slot_w;
    logic                 slot_ok;
    logic [AW-1:0]        slot_a;
    sbc_pkg::func_t       fn;

    assign accept  = start && !busy;
    assign slot_w  = SW'(slot);
    assign slot_ok = (slot_w < SW'(ENTRIES));
    assign slot_a  = AW'(slot_w);
    assign fn      = sbc_pkg::func_t'(func);

    // ---------------- entry RAM ----------------
    sbc_pkg::entry_t      wr_entry;
    sbc_pkg::entry_t      rd_entry;
    logic                 ram_we;
    logic [AW-1:0]        ram_raddr;

    assign wr_entry.pos_x        = pos_x;
    assign wr_entry.pos_y        = pos_y;
    assign wr_entry.width        = width;
    assign wr_entry.height       = height;
    assign wr_entry.inset_left   = inset_left;
    assign wr_entry.inset_right  = inset_right;
    assign wr_entry.inset_top    = inset_top;
    assign wr_entry.inset_bottom = inset_bottom;
    assign wr_entry.hit_mask     = hit_mask;

    assign ram_we = accept && (fn == sbc_pkg::FUNC_WRITE) && slot_ok;

    sbc_ram #(
        .WIDTH ($bits(sbc_pkg::entry_t)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_a),
        .wdata (wr_entry),
        .raddr (ram_raddr),
        .rdata (rd_entry)
    );

    // Box of whatever entry is on the read port: own entry in ST_SELF,
    // the scanned entry in ST_SCAN.
    sbc_pkg::box_t        rd_box;

    sbc_box #(
        .FRAC_BITS (FRAC_BITS)
    ) u_box (
        .entry (rd_entry),
        .box   (rd_box)
    );

    // ---------------- scan compare ----------------
    logic                 touch;
    logic                 hit;
    logic                 scan_end;
    logic [3:0]           count_inc;

    assign touch = (self_box_reg.l <= rd_box.r) && (self_box_reg.r >= rd_box.l) &&
                   (self_box_reg.t <= rd_box.b) && (self_box_reg.b >= rd_box.t);

    assign hit = (sc_reg != self_idx_reg) && active_reg[sc_reg] &&
                 ((self_mask_reg & rd_entry.hit_mask) != 8'd0) && touch;

    assign scan_end  = (sc_reg == AW'(ENTRIES - 1));
    assign count_inc = count_reg + 4'd1;

    assign busy = (state_reg != ST_IDLE);

    // ---------------- control ----------------
    always_comb
    begin
        state_next      = state_reg;
        active_next     = active_reg;
        self_idx_next   = self_idx_reg;
        sc_next         = sc_reg;
        max_next        = max_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_count_next = pend_count_reg;
        self_box_next   = self_box_reg;
        self_mask_next  = self_mask_reg;
        ram_raddr       = slot_a;

        strobe_next     = 1'b0;
        hit_valid_next  = hit_valid_reg;
        hit_slot_next   = hit_slot_reg;
        hit_count_next  = hit_count_reg;
        last_next       = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (fn)
                        sbc_pkg::FUNC_WRITE:
                        begin
                            if (slot_ok)
                            begin
                                active_next[slot_a] = 1'b1;
                            end
                        end
                        sbc_pkg::FUNC_REMOVE:
                        begin
                            if (slot_ok)
                            begin
                                active_next[slot_a] = 1'b0;
                            end
                        end
                        sbc_pkg::FUNC_QUERY:
                        begin
                            if (slot_ok && active_reg[slot_a] && (max_hits != 4'd0))
                            begin
                                // own entry read issued at slot_a this cycle
                                self_idx_next   = slot_a;
                                max_next        = max_hits;
                                count_next      = 4'd0;
                                pend_valid_next = 1'b0;
                                state_next      = ST_SELF;
                            end
                            else
                            begin
                                strobe_next    = 1'b1;
                                hit_valid_next = 1'b0;
                                hit_slot_next  = 4'd0;
                                hit_count_next = 4'd0;
                                last_next      = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SELF:
            begin
                self_box_next  = rd_box;
                self_mask_next = rd_entry.hit_mask;
                ram_raddr      = '0;
                sc_next        = '0;
                state_next     = ST_SCAN;
            end

            ST_SCAN:
            begin
                ram_raddr = scan_end ? '0 : sc_reg + 1'b1;
                sc_next   = sc_reg + 1'b1;
                if (hit)
                begin
                    // held hit is not the last one: release it now
                    if (pend_valid_reg)
                    begin
                        strobe_next    = 1'b1;
                        hit_valid_next = 1'b1;
                        hit_slot_next  = pend_slot_reg;
                        hit_count_next = pend_count_reg;
                        last_next      = 1'b0;
                    end
                    count_next      = count_inc;
                    pend_valid_next = 1'b1;
                    pend_slot_next  = 4'(sc_reg);
                    pend_count_next = count_inc;
                end
                if ((hit && (count_inc == max_reg)) || scan_end)
                begin
                    state_next = ST_FLUSH;
                end
            end

            ST_FLUSH:
            begin
                strobe_next    = 1'b1;
                hit_valid_next = pend_valid_reg;
                hit_slot_next  = pend_valid_reg ? pend_slot_reg : 4'd0;
                hit_count_next = pend_valid_reg ? pend_count_reg : 4'd0;
                last_next      = 1'b1;
                state_next     = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            active_reg     <= '0;
            strobe_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            count_reg      <= 4'd0;
        end
        else
        begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            strobe_reg     <= strobe_next;
            pend_valid_reg <= pend_valid_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        self_idx_reg   <= self_idx_next;
        sc_reg         <= sc_next;
        max_reg        <= max_next;
        pend_slot_reg  <= pend_slot_next;
        pend_count_reg <= pend_count_next;
        self_box_reg   <= self_box_next;
        self_mask_reg  <= self_mask_next;
        hit_valid_reg  <= hit_valid_next;
        hit_slot_reg   <= hit_slot_next;
        hit_count_reg  <= hit_count_next;
        last_reg       <= last_next;
    end

    assign strobe    = strobe_reg;
    assign hit_valid = hit_valid_reg;
    assign hit_slot  = hit_slot_reg;
    assign hit_count = hit_count_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire
